>>> sv/uesc_pkg.sv
// Package: shared types, character codes and the hex digit value function.
`default_nettype none
package uesc_pkg;

  localparam logic [7:0] BACKSLASH_CODE = 8'h5C;
  localparam logic [7:0] LETTER_U_CODE  = 8'h75;
  localparam logic [7:0] DIGIT_BASE     = 8'd48;
  localparam logic [7:0] LOWER_LIMIT    = 8'd48;
  localparam logic [7:0] LOWER_ADJUST   = 8'd39;
  localparam logic [7:0] UPPER_LIMIT    = 8'd9;
  localparam logic [7:0] UPPER_ADJUST   = 8'd7;
  localparam logic [7:0] LEAD_BASE      = 8'hE0;
  localparam logic [7:0] CONT_BASE      = 8'h80;

  typedef enum logic [2:0] {
    PH_PLAIN  = 3'd0,
    PH_BSLASH = 3'd1,
    PH_U      = 3'd2,
    PH_D1     = 3'd3,
    PH_D2     = 3'd4,
    PH_D3     = 3'd5
  } phase_t;

  // Up to three result bytes from one input item; last marks the final one.
  typedef struct packed {
    logic [1:0]      cnt;
    logic            last;
    logic [2:0][7:0] data;
  } bundle_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] h;
    h = c - DIGIT_BASE;
    if (h > LOWER_LIMIT) begin
      h = h - LOWER_ADJUST;
    end else if (h > UPPER_LIMIT) begin
      h = h - UPPER_ADJUST;
    end
    return h;
  endfunction

endpackage
`default_nettype wire

>>> sv/unicode_escape_to_utf8_top.sv
// Top level: JSON-style \uXXXX escape to three-byte UTF-8 stream converter.
//
// Input channel in_valid/in_ready carries one text byte (in_byte) and an
// end-of-text mark (in_last). Output channel out_valid/out_ready carries one
// converted byte (out_byte) and its end mark (out_last).
// Plain bytes pass through; backslash, 'u' and four digits become three bytes.
// The first byte of an item's result appears on the output the cycle after the
// item is accepted. An item that yields zero or one byte keeps the input ready
// while out_ready is high, so plain text then moves at one byte per cycle. An
// item that yields two or three bytes holds in_ready low while the result
// register drains one byte per cycle, as out_ready allows, down to its final
// byte; the next item can be taken in the cycle that final byte leaves.
// While the receiver stalls, the pending byte holds and in_ready stays low
// once the result register cannot take the next item's bytes.
// Reset clears the escape phase to plain copying and empties the result
// register; no item is lost or invented across a stall.
`default_nettype none
module unicode_escape_to_utf8_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  import uesc_pkg::*;

  bundle_t bun;
  logic    accept;

  assign accept = in_valid && in_ready;

  uesc_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .bun     (bun)
  );

  uesc_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .space     (in_ready),
    .bun       (bun),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire

>>> sv/uesc_decode.sv
// Escape decoder: phase and digit registers, per-item result bundle.
`default_nettype none
module uesc_decode (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_last,
  output uesc_pkg::bundle_t     bun
);
  import uesc_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] dv [3];
  logic [7:0] dval;

  assign dval = digit_value(in_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PLAIN;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_last) begin
      unique case (phase)
        PH_U:    dv[0] <= dval;
        PH_D1:   dv[1] <= dval;
        PH_D2:   dv[2] <= dval;
        default: ;
      endcase
    end
  end

  always_comb begin
    bun        = '0;
    phase_next = PH_PLAIN;
    unique case (phase)
      PH_BSLASH: begin
        if (in_byte == LETTER_U_CODE) begin
          if (in_last) begin
            bun.cnt     = 2'd1;
            bun.last    = 1'b1;
            bun.data[0] = BACKSLASH_CODE;
          end else begin
            phase_next = PH_U;
          end
        end else begin
          bun.data[0] = BACKSLASH_CODE;
          if (in_byte == BACKSLASH_CODE) begin
            if (in_last) begin
              bun.cnt     = 2'd2;
              bun.last    = 1'b1;
              bun.data[1] = BACKSLASH_CODE;
            end else begin
              bun.cnt    = 2'd1;
              phase_next = PH_BSLASH;
            end
          end else begin
            bun.cnt     = 2'd2;
            bun.last    = in_last;
            bun.data[1] = in_byte;
          end
        end
      end
      PH_U, PH_D1, PH_D2: begin
        if (in_last) begin
          bun.cnt     = 2'd1;
          bun.last    = 1'b1;
          bun.data[0] = BACKSLASH_CODE;
        end else begin
          unique case (phase)
            PH_U:    phase_next = PH_D1;
            PH_D1:   phase_next = PH_D2;
            default: phase_next = PH_D3;
          endcase
        end
      end
      PH_D3: begin
        bun.cnt     = 2'd3;
        bun.last    = in_last;
        bun.data[0] = LEAD_BASE + dv[0];
        bun.data[1] = CONT_BASE + {dv[1][5:0], 2'b00} + {2'b00, dv[2][7:2]};
        bun.data[2] = CONT_BASE + {2'b00, dv[2][1:0], 4'b0000} + dval;
      end
      default: begin
        if (in_byte == BACKSLASH_CODE) begin
          if (in_last) begin
            bun.cnt     = 2'd1;
            bun.last    = 1'b1;
            bun.data[0] = BACKSLASH_CODE;
          end else begin
            phase_next = PH_BSLASH;
          end
        end else begin
          bun.cnt     = 2'd1;
          bun.last    = in_last;
          bun.data[0] = in_byte;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

>>> sv/uesc_outbuf.sv
// Result register: holds one bundle, hands its bytes out one per ready cycle.
`default_nettype none
module uesc_outbuf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   space,
  input  uesc_pkg::bundle_t      bun,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last
);
  import uesc_pkg::*;

  logic [1:0]      rem;
  logic [1:0]      rem_next;
  logic            last;
  logic [2:0][7:0] data;
  logic            pop;
  logic            load;

  assign out_valid = (rem != 2'd0);
  assign pop       = out_valid && out_ready;
  assign space     = (rem == 2'd0) || (rem == 2'd1 && out_ready);
  assign load      = in_valid && space;
  assign out_byte  = data[0];
  assign out_last  = last && (rem == 2'd1);

  always_comb begin
    rem_next = rem;
    if (load) begin
      rem_next = bun.cnt;
    end else if (pop) begin
      rem_next = rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else begin
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= bun.data;
      last <= bun.last;
    end else if (pop) begin
      data <= {8'h00, data[2], data[1]};
    end
  end

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> rem == $past(bun.cnt))
    else $error("result count not loaded from bundle");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !load) |=> rem == $past(rem) - 2'd1)
    else $error("result count not decremented on pop");

  a_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load && rem != 2'd0) |-> (rem == 2'd1 && out_ready))
    else $error("pending result overwritten");

  a_last_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last && out_ready) |=> (rem == 2'd0 || $past(load)))
    else $error("bytes left after final byte");

endmodule
`default_nettype wire

>>> dv/tb_unicode_escape_to_utf8_top.sv
// Testbench for unicode_escape_to_utf8_top: directed table plus random text vs a predictor.
module tb_unicode_escape_to_utf8_top;
  import uesc_pkg::*;

  localparam int STALL_LIMIT   = 200;
  localparam int RANDOM_ITEMS  = 296;
  localparam int SETTLE_CYCLES = 8;

  // {last, byte}: reads as 9'h15C for a backslash marked last
  typedef struct packed {
    logic       l;
    logic [7:0] b;
  } utf_byte_t;

  typedef struct packed {
    logic [7:0]           b;
    logic                 l;
    logic                 typed;
    logic [1:0]           cnt;
    utf_byte_t [0:2]      fix;
  } stim_row_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  utf_byte_t  expected_bytes [$];
  utf_byte_t  stim_q [$];
  phase_t     esc_phase = PH_PLAIN;
  logic [7:0] held_digits [3] = '{8'h00, 8'h00, 8'h00};
  int         errors = 0;
  int         idle_cycles = 0;
  bit         calm = 1'b0;

  stim_row_t directed_rows [25] = '{
    '{8'h41, 1'b0, 1'b1, 2'd1, {9'h041, 9'h000, 9'h000}},
    '{8'h00, 1'b0, 1'b1, 2'd1, {9'h000, 9'h000, 9'h000}},
    '{8'hFF, 1'b1, 1'b1, 2'd1, {9'h1FF, 9'h000, 9'h000}},
    '{8'h5C, 1'b0, 1'b1, 2'd0, '0},
    '{8'h75, 1'b0, 1'b1, 2'd0, '0},
    '{8'h30, 1'b0, 1'b1, 2'd0, '0},
    '{8'h30, 1'b0, 1'b1, 2'd0, '0},
    '{8'h30, 1'b0, 1'b1, 2'd0, '0},
    '{8'h30, 1'b0, 1'b1, 2'd3, {9'h0E0, 9'h080, 9'h080}},
    '{8'h5C, 1'b0, 1'b1, 2'd0, '0},
    '{8'h75, 1'b0, 1'b1, 2'd0, '0},
    '{8'h46, 1'b0, 1'b1, 2'd0, '0},
    '{8'hFF, 1'b0, 1'b1, 2'd0, '0},
    '{8'h00, 1'b0, 1'b1, 2'd0, '0},
    '{8'h66, 1'b1, 1'b0, 2'd0, '0},
    '{8'h5C, 1'b0, 1'b1, 2'd0, '0},
    '{8'h78, 1'b0, 1'b1, 2'd2, {9'h05C, 9'h078, 9'h000}},
    '{8'h5C, 1'b0, 1'b1, 2'd0, '0},
    '{8'h5C, 1'b0, 1'b1, 2'd1, {9'h05C, 9'h000, 9'h000}},
    '{8'h75, 1'b1, 1'b1, 2'd1, {9'h15C, 9'h000, 9'h000}},
    '{8'h5C, 1'b1, 1'b1, 2'd1, {9'h15C, 9'h000, 9'h000}},
    '{8'h5C, 1'b0, 1'b1, 2'd0, '0},
    '{8'h75, 1'b0, 1'b1, 2'd0, '0},
    '{8'h31, 1'b0, 1'b1, 2'd0, '0},
    '{8'h32, 1'b1, 1'b1, 2'd1, {9'h15C, 9'h000, 9'h000}}
  };

  unicode_escape_to_utf8_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] offset;
    offset = c - 8'd48;
    return (offset > 8'd48) ? offset - 8'd39 : ((offset > 8'd9) ? offset - 8'd7 : offset);
  endfunction

  task automatic convert_item(input logic [7:0] b, input logic l,
                              output utf_byte_t [0:2] res, output int n);
    logic [7:0] lead;
    logic [7:0] mid;
    logic [7:0] tail;
    bit         plain_pass;
    n = 0;
    res = '0;
    plain_pass = (esc_phase == PH_PLAIN);
    case (esc_phase)
      PH_BSLASH: begin
        if (b == LETTER_U_CODE) begin
          if (l) begin
            res[0] = {1'b1, BACKSLASH_CODE};
            n = 1;
            esc_phase = PH_PLAIN;
          end else begin
            esc_phase = PH_U;
          end
        end else begin
          res[0] = {1'b0, BACKSLASH_CODE};
          n = 1;
          plain_pass = 1'b1;
        end
      end
      PH_U, PH_D1, PH_D2: begin
        if (l) begin
          res[0] = {1'b1, BACKSLASH_CODE};
          n = 1;
          esc_phase = PH_PLAIN;
        end else begin
          held_digits[int'(esc_phase) - int'(PH_U)] = hex_value(b);
          esc_phase = phase_t'(esc_phase + 3'd1);
        end
      end
      PH_D3: begin
        lead = LEAD_BASE + held_digits[0];
        mid  = CONT_BASE + (held_digits[1] << 2) + (held_digits[2] >> 2);
        tail = CONT_BASE + {held_digits[2][1:0], 4'h0} + hex_value(b);
        res  = {{1'b0, lead}, {1'b0, mid}, {l, tail}};
        n = 3;
        esc_phase = PH_PLAIN;
      end
      default: begin
      end
    endcase
    if (plain_pass) begin
      if (b == BACKSLASH_CODE && !l) begin
        esc_phase = PH_BSLASH;
      end else begin
        res[n] = {l, b};
        n++;
        esc_phase = PH_PLAIN;
      end
    end
  endtask

  task automatic queue_bytes(input utf_byte_t [0:2] r, input int n);
    for (int k = 0; k < n; k++) begin
      expected_bytes.insert(expected_bytes.size(), r[k]);
    end
  endtask

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 10) begin
      $display("ERROR at %0t: %s", $time, what);
    end
  endtask

  // drain: hold off until every pending result byte has come out
  task automatic send_byte(input utf_byte_t item, input bit drain);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0 || drain) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (drain && expected_bytes.size() != 0);
      for (int k = 1; k < gap; k++) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= item.b;
    in_last  <= item.l;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic coin_last();
    return $urandom_range(0, 11) == 0;
  endfunction

  function automatic logic [7:0] any_digit();
    logic [7:0] r;
    r = 8'($urandom_range(0, 15));
    if ($urandom_range(0, 7) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    if (r < 8'd10) begin
      return 8'h30 + r;
    end
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + r - 8'd10;
  endfunction

  task automatic add_stim(input utf_byte_t item);
    stim_q.insert(stim_q.size(), item);
  endtask

  task automatic add_chunk();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      add_stim(utf_byte_t'({coin_last(), BACKSLASH_CODE}));
      add_stim(utf_byte_t'({coin_last(), LETTER_U_CODE}));
      repeat (4) add_stim(utf_byte_t'({coin_last(), any_digit()}));
    end else if (kind < 6) begin
      add_stim(utf_byte_t'({coin_last(), BACKSLASH_CODE}));
      add_stim(utf_byte_t'({coin_last(), 8'($urandom_range(0, 255))}));
    end else begin
      add_stim(utf_byte_t'({coin_last(), 8'($urandom_range(0, 255))}));
    end
  endtask

  initial begin
    utf_byte_t [0:2] res;
    int              n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      send_byte({directed_rows[i].l, directed_rows[i].b}, 1'b0);
      convert_item(directed_rows[i].b, directed_rows[i].l, res, n);
      if (directed_rows[i].typed) begin
        queue_bytes(directed_rows[i].fix, int'(directed_rows[i].cnt));
      end else begin
        queue_bytes(res, n);
      end
    end
    while (stim_q.size() < RANDOM_ITEMS) add_chunk();
    for (int i = 0; i < stim_q.size(); i++) begin
      calm = (i >= 100 && i < 150);
      send_byte(stim_q[i], i == 200);
      convert_item(stim_q[i].b, stim_q[i].l, res, n);
      queue_bytes(res, n);
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    int        stall;
    utf_byte_t want;
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_bytes.size() == 0) begin
        flag_error($sformatf("unexpected item byte=%02h last=%0b", out_byte, out_last));
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.b) begin
          flag_error($sformatf("out_byte exp %02h got %02h", want.b, out_byte));
        end
        if (out_last !== want.l) begin
          flag_error($sformatf("out_last exp %0b got %0b (byte %02h)", want.l, out_last,
                               want.b));
        end
      end
    end
  end

  initial begin
    while (rst) @(posedge clk);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule
